[rtl/wps_pkg.sv]
// shared types, constants and recipe table for the wash program sequencer
`default_nettype none
package wps_pkg;

	localparam int unsigned TPS_W = 16;
	localparam int unsigned TICK_W = 22;
	localparam int unsigned REP_W = 3;
	localparam int unsigned TEMP_W = 8;
	localparam int unsigned SECONDS_PER_REPEAT = 60;
	localparam int unsigned TPS_RESET = 10000;
	localparam logic [TICK_W-1:0] PERIOD_RESET = TICK_W'(SECONDS_PER_REPEAT * TPS_RESET);

	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_START = 1'b1;

	localparam logic [1:0] PROG_UNKNOWN = 2'd3;
	localparam logic [1:0] RECIPE_A = 2'd0;
	localparam logic [1:0] LAST_WASH = 2'd2;
	localparam logic [1:0] LEVEL_EMPTY = 2'd0;

	localparam logic [1:0] SOAP_NONE = 2'd0;
	localparam logic [1:0] SOAP_ONE = 2'd1;
	localparam logic [1:0] SOAP_TWO = 2'd2;

	localparam logic [1:0] SPEED_STOP = 2'd0;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'd0,
		ST_FILL  = 3'd1,
		ST_HEAT  = 3'd2,
		ST_MOT1  = 3'd3,
		ST_MOT2  = 3'd4,
		ST_DRAIN = 3'd5
	} stage_t;

	typedef struct packed {
		logic [1:0]        level;
		logic [TEMP_W-1:0] heat;
		logic [1:0]        soap;
		logic [REP_W-1:0]  rep1;
		logic [1:0]        spd1;
		logic [REP_W-1:0]  rep2;
		logic [1:0]        spd2;
	} wash_t;

	typedef struct packed {
		logic       door;
		logic       soap_two;
		logic       soap_one;
		logic [1:0] speed;
		logic       clockwise;
		logic       outlet;
		logic       inlet;
		logic       heater;
	} act_t;

	typedef struct packed {
		stage_t            stage;
		logic [1:0]        wash_index;
		logic [REP_W-1:0]  repeat_count;
		logic [TICK_W-1:0] tick_count;
		logic [1:0]        recipe;
		logic [1:0]        led_select;
		act_t              act;
	} state_t;

	typedef struct packed {
		logic              req_type;
		logic [1:0]        program_select;
		logic [1:0]        water_level;
		logic [TEMP_W-1:0] temperature;
	} in_t;

	typedef struct packed {
		logic       heater_on;
		logic       inlet_open;
		logic       outlet_open;
		logic       motor_clockwise;
		logic [1:0] motor_speed;
		logic       soap_one_led;
		logic       soap_two_led;
		logic       door_locked;
		logic [1:0] program_led;
		logic       running;
		logic       program_done;
	} out_t;

	localparam wash_t RECIPE_TABLE [0:2][0:2] = '{
		'{
			'{2'd2, 8'd0,  2'd1, 3'd1, 2'd1, 3'd1, 2'd1},
			'{2'd2, 8'd2,  2'd2, 3'd2, 2'd2, 3'd2, 2'd2},
			'{2'd2, 8'd0,  2'd0, 3'd2, 2'd2, 3'd2, 2'd2}
		},
		'{
			'{2'd2, 8'd2,  2'd1, 3'd1, 2'd2, 3'd1, 2'd2},
			'{2'd2, 8'd50, 2'd2, 3'd2, 2'd2, 3'd2, 2'd2},
			'{2'd2, 8'd0,  2'd0, 3'd2, 2'd2, 3'd2, 2'd2}
		},
		'{
			'{2'd2, 8'd2,  2'd1, 3'd1, 2'd2, 3'd1, 2'd2},
			'{2'd3, 8'd3,  2'd2, 3'd4, 2'd3, 3'd4, 2'd3},
			'{2'd2, 8'd0,  2'd0, 3'd4, 2'd3, 3'd4, 2'd3}
		}
	};

	function automatic wash_t recipe_wash(input logic [1:0] r, input logic [1:0] w);
		logic [1:0] ri;
		logic [1:0] wi;
		ri = (r > 2'd2) ? 2'd0 : r;
		wi = (w > 2'd2) ? 2'd0 : w;
		return RECIPE_TABLE[ri][wi];
	endfunction

endpackage
`default_nettype wire

[rtl/wps_step.sv]
// next-state and result logic for one transaction
`default_nettype none
module wps_step (
	input  wps_pkg::state_t              st,
	input  wps_pkg::in_t                 req,
	input  logic [wps_pkg::TICK_W-1:0]   period,
	output wps_pkg::state_t              st_next,
	output wps_pkg::out_t                result
);
	import wps_pkg::*;

	wash_t             w;
	logic              was_running;
	logic              now_running;
	logic              done;
	logic              heat_low;
	logic [1:0]        new_recipe;
	logic [TICK_W-1:0] tick_inc;
	logic [REP_W-1:0]  rep_inc;
	logic [REP_W-1:0]  reps;
	logic              tick_wrap;
	logic              phase_end;

	assign w = recipe_wash(st.recipe, st.wash_index);
	assign was_running = (st.stage == ST_FILL) || (st.stage == ST_HEAT) ||
		(st.stage == ST_MOT1) || (st.stage == ST_MOT2) || (st.stage == ST_DRAIN);
	assign heat_low = req.temperature < w.heat;
	assign new_recipe = (req.program_select == PROG_UNKNOWN) ? st.recipe : req.program_select;

	// motor repeat counting
	assign reps = (st.stage == ST_MOT2) ? w.rep2 : w.rep1;
	assign tick_inc = st.tick_count + TICK_W'(1);
	assign tick_wrap = tick_inc >= period;
	assign rep_inc = st.repeat_count + REP_W'(1);
	assign phase_end = tick_wrap && (rep_inc >= reps);

	always_comb begin
		st_next = st;
		done = 1'b0;
		if (req.req_type == REQ_START) begin
			if (!was_running) begin
				st_next.recipe = new_recipe;
				st_next.led_select = new_recipe + 2'd1;
				st_next.wash_index = 2'd0;
				st_next.repeat_count = '0;
				st_next.tick_count = '0;
				st_next.act.heater = 1'b0;
				st_next.act.outlet = 1'b0;
				st_next.act.inlet = 1'b1;
				st_next.act.door = 1'b1;
				st_next.stage = ST_FILL;
			end
		end else begin
			unique case (st.stage)
				ST_FILL: begin
					st_next.act.heater = heat_low;
					if (req.water_level >= w.level) begin
						st_next.act.inlet = 1'b0;
						st_next.stage = ST_HEAT;
					end
				end
				ST_HEAT: begin
					st_next.act.heater = heat_low;
					if (!heat_low) begin
						if (w.soap == SOAP_NONE) begin
							st_next.act.soap_one = 1'b0;
							st_next.act.soap_two = 1'b0;
						end else if (w.soap == SOAP_ONE) begin
							st_next.act.soap_one = 1'b1;
							st_next.act.soap_two = 1'b0;
						end else if (w.soap == SOAP_TWO) begin
							st_next.act.soap_one = 1'b0;
							st_next.act.soap_two = 1'b1;
						end
						st_next.act.clockwise = 1'b1;
						st_next.act.speed = w.spd1;
						st_next.repeat_count = '0;
						st_next.tick_count = '0;
						st_next.stage = ST_MOT1;
					end
				end
				ST_MOT1, ST_MOT2: begin
					st_next.act.heater = heat_low;
					if (tick_wrap) begin
						st_next.tick_count = '0;
						st_next.repeat_count = phase_end ? '0 : rep_inc;
					end else begin
						st_next.tick_count = tick_inc;
					end
					if (phase_end) begin
						if (st.stage == ST_MOT1) begin
							st_next.act.clockwise = 1'b0;
							st_next.act.speed = w.spd2;
							st_next.stage = ST_MOT2;
						end else begin
							st_next.act.soap_one = 1'b0;
							st_next.act.soap_two = 1'b0;
							st_next.act.heater = 1'b0;
							st_next.act.speed = SPEED_STOP;
							st_next.act.outlet = 1'b1;
							st_next.stage = ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (req.water_level == LEVEL_EMPTY) begin
						st_next.act.outlet = 1'b0;
						if (st.wash_index >= LAST_WASH) begin
							st_next.wash_index = 2'd0;
							st_next.act.door = 1'b0;
							st_next.stage = ST_IDLE;
							done = 1'b1;
						end else begin
							st_next.wash_index = st.wash_index + 2'd1;
							st_next.act.inlet = 1'b1;
							st_next.stage = ST_FILL;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign now_running = (st_next.stage == ST_FILL) || (st_next.stage == ST_HEAT) ||
		(st_next.stage == ST_MOT1) || (st_next.stage == ST_MOT2) ||
		(st_next.stage == ST_DRAIN);

	always_comb begin
		result.heater_on = st_next.act.heater;
		result.inlet_open = st_next.act.inlet;
		result.outlet_open = st_next.act.outlet;
		result.motor_clockwise = st_next.act.clockwise;
		result.motor_speed = st_next.act.speed;
		result.soap_one_led = st_next.act.soap_one;
		result.soap_two_led = st_next.act.soap_two;
		result.door_locked = st_next.act.door;
		result.program_led = st_next.led_select;
		result.running = now_running;
		result.program_done = done;
	end

endmodule
`default_nettype wire

[rtl/wps_out_stage.sv]
// result register with valid/stall handshake
`default_nettype none
module wps_out_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  wps_pkg::out_t  load_data,
	output logic           can_load,
	output logic           out_valid,
	input  logic           out_stall,
	output wps_pkg::out_t  out_data
);
	import wps_pkg::*;

	logic valid_q;
	out_t data_q;

	assign can_load = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign out_data = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			data_q <= load_data;
		end
	end

endmodule
`default_nettype wire

[rtl/wash_program_sequencer.sv]
// top level of the wash program sequencer
// Usage:
//   in channel: in_valid / in_stall / in_data. A transaction is either a tick
//   carrying water level and temperature, or a start request with a program
//   code. Every input transaction yields exactly one output transaction on
//   out_valid / out_stall / out_data carrying all actuator states.
//   cfg_we / cfg_wdata write ticks_per_second; write only while no transaction
//   is in flight. A motor repeat lasts 60 * ticks_per_second ticks.
// Path: an accepted input passes through the input register, then the
//   sequencer step into the result register, before out_valid rises.
// Throughput: one transaction per cycle while out_stall is low; the whole
//   sequencer step is a combinational compare-and-advance on the state registers.
// Reset: arst_n clears the state to idle, recipe A, all actuators off and
//   ticks_per_second to 10000; no transaction is held.
// Stall: when out_stall holds a waiting result, the input register still
//   accepts one more transaction; in_stall rises once both are occupied.
`default_nettype none
module wash_program_sequencer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  wps_pkg::in_t                in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output wps_pkg::out_t               out_data,
	input  logic                        cfg_we,
	input  logic [wps_pkg::TPS_W-1:0]   cfg_wdata
);
	import wps_pkg::*;

	logic              valid_s1;
	in_t               data_s1;
	state_t            state_q;
	state_t            state_next;
	out_t              result;
	logic [TICK_W-1:0] period_q;
	logic              can_load;
	logic              advance;

	assign advance = valid_s1 && can_load;
	assign in_stall = valid_s1 && !can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
		end else if (cfg_we) begin
			period_q <= TICK_W'(cfg_wdata) * TICK_W'(SECONDS_PER_REPEAT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.stage <= ST_IDLE;
			state_q.wash_index <= '0;
			state_q.repeat_count <= '0;
			state_q.tick_count <= '0;
			state_q.recipe <= RECIPE_A;
			state_q.led_select <= '0;
			state_q.act <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	wps_step u_step (
		.st      (state_q),
		.req     (data_s1),
		.period  (period_q),
		.st_next (state_next),
		.result  (result)
	);

	wps_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (valid_s1),
		.load_data (result),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire
